### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sync-framed deframer with Fletcher check.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND     = 8'h62;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd400;

    // Depth of the queue between the parser and the checksum/output stage
    localparam int SFD_QDEPTH = 2;
    localparam int SFD_QPTR_W = (SFD_QDEPTH > 1) ? $clog2(SFD_QDEPTH) : 1;
    localparam int SFD_QCNT_W = $clog2(SFD_QDEPTH + 1);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CHK_LO,
        PH_CHK_HI
    } t_phase;

    // Work handed from the parser to the back end
    typedef enum logic [2:0] {
        OP_HEAD_FIRST,  // class byte: restart the sums
        OP_HEAD,        // id or length byte: sum only
        OP_PAYLOAD,     // sum and pass the byte out
        OP_CHK_LO,      // hold first check byte
        OP_CHK_HI,      // compare and report verdict
        OP_TOO_LONG     // report oversized frame
    } t_op;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [7:0]  hdr_class;
        logic [7:0]  msg_id;
        logic [15:0] length;
        logic [15:0] index;
    } t_qentry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

endpackage

### rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if / sfd_cfg_if
// Valid/ready channels of the deframer: received bytes, results, config.
// ----------------------------------------------------------------------------
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  hdr_class;
    logic [7:0]  msg_id;
    logic [15:0] hdr_length;
    logic [15:0] payload_index;

    modport source (output valid, output kind, output data_byte, output hdr_class,
                    output msg_id, output hdr_length, output payload_index,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input hdr_class,
                    input msg_id, input hdr_length, input payload_index,
                    output ready);
endinterface

interface sfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_frame_len;

    modport source (output valid, output max_frame_len, input ready);
    modport sink   (input valid, input max_frame_len, output ready);
endinterface

### rtl/sync_frame_deframer_fletcher8_top.sv
// ----------------------------------------------------------------------------
// sync_frame_deframer_fletcher8_top
// Byte-stream deframer for 0xB5 0x62 sync frames with an 8-bit Fletcher check.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle on i_rx while the queue has room, so a
// stream of bytes may arrive back to back. Payload bytes reach o_res through
// the queue and output register, tagged with class, id, announced length and
// position; the second check byte gives a good or bad verdict, and a header
// whose length exceeds the configured maximum (reset 400) gives a too-long
// report and restarts the hunt. Parser and checksum/output stage are joined by
// a two-entry queue, so i_rx keeps flowing until that queue fills behind a
// stalled o_res. Write the maximum through i_cfg only while the block is idle.
module sync_frame_deframer_fletcher8_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfd_in_if.sink    i_rx,
    sfd_cfg_if.sink   i_cfg,
    sfd_out_if.source o_res
);

    sfd_pkg::t_qstat  qstat;
    sfd_pkg::t_qentry push_entry;
    sfd_pkg::t_qentry head_entry;
    logic             push;
    logic             pop;

    sfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_entry (push_entry)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_stat  (qstat),
        .o_entry (head_entry)
    );

    sfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

### rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Frame parser: tracks sync, header, length and payload position, and queues
// one work entry per byte that needs summing, checking or reporting.
// ----------------------------------------------------------------------------
module sfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfd_in_if.sink            i_rx,
    sfd_cfg_if.sink           i_cfg,
    input  sfd_pkg::t_qstat   i_qstat,
    output logic              o_push,
    output sfd_pkg::t_qentry  o_entry
);

    sfd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_max;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;

    logic        acc;
    logic        push;
    logic [7:0]  b;
    logic [15:0] len_full;
    logic        too_long;
    logic [15:0] cnt_inc;

    assign i_rx.ready  = !i_qstat.full;
    assign i_cfg.ready = 1'b1;
    assign acc         = i_rx.valid && i_rx.ready;
    assign b           = i_rx.rx_byte;
    assign len_full    = {b, r_len_lo};
    assign too_long    = len_full > r_max;
    assign cnt_inc     = r_cnt + 16'd1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            sfd_pkg::PH_HUNT:
                n_phase = (b == sfd_pkg::SYNC_FIRST) ? sfd_pkg::PH_SYNC2 : sfd_pkg::PH_HUNT;
            sfd_pkg::PH_SYNC2: begin
                if (b == sfd_pkg::SYNC_SECOND) begin
                    n_phase = sfd_pkg::PH_CLASS;
                end else if (b == sfd_pkg::SYNC_FIRST) begin
                    n_phase = sfd_pkg::PH_SYNC2;
                end else begin
                    n_phase = sfd_pkg::PH_HUNT;
                end
            end
            sfd_pkg::PH_CLASS:  n_phase = sfd_pkg::PH_ID;
            sfd_pkg::PH_ID:     n_phase = sfd_pkg::PH_LEN_LO;
            sfd_pkg::PH_LEN_LO: n_phase = sfd_pkg::PH_LEN_HI;
            sfd_pkg::PH_LEN_HI: begin
                if (too_long) begin
                    n_phase = sfd_pkg::PH_HUNT;
                end else if (len_full == 16'd0) begin
                    n_phase = sfd_pkg::PH_CHK_LO;
                end else begin
                    n_phase = sfd_pkg::PH_PAYLOAD;
                end
            end
            sfd_pkg::PH_PAYLOAD:
                n_phase = (cnt_inc >= r_len) ? sfd_pkg::PH_CHK_LO : sfd_pkg::PH_PAYLOAD;
            sfd_pkg::PH_CHK_LO: n_phase = sfd_pkg::PH_CHK_HI;
            sfd_pkg::PH_CHK_HI: n_phase = sfd_pkg::PH_HUNT;
            default:
                n_phase = (b == sfd_pkg::SYNC_FIRST) ? sfd_pkg::PH_SYNC2 : sfd_pkg::PH_HUNT;
        endcase
    end

    // Queue entry and header registers
    always_comb begin
        push     = 1'b0;
        n_class  = r_class;
        n_id     = r_id;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_cnt    = r_cnt;
        o_entry.op    = sfd_pkg::OP_HEAD;
        o_entry.index = 16'd0;
        unique case (r_phase)
            sfd_pkg::PH_CLASS: begin
                push       = 1'b1;
                n_class    = b;
                o_entry.op = sfd_pkg::OP_HEAD_FIRST;
            end
            sfd_pkg::PH_ID: begin
                push = 1'b1;
                n_id = b;
            end
            sfd_pkg::PH_LEN_LO: begin
                push     = 1'b1;
                n_len_lo = b;
            end
            sfd_pkg::PH_LEN_HI: begin
                push       = 1'b1;
                n_len      = len_full;
                n_cnt      = 16'd0;
                o_entry.op = too_long ? sfd_pkg::OP_TOO_LONG : sfd_pkg::OP_HEAD;
            end
            sfd_pkg::PH_PAYLOAD: begin
                push          = 1'b1;
                n_cnt         = cnt_inc;
                o_entry.op    = sfd_pkg::OP_PAYLOAD;
                o_entry.index = r_cnt;
            end
            sfd_pkg::PH_CHK_LO: begin
                push       = 1'b1;
                o_entry.op = sfd_pkg::OP_CHK_LO;
            end
            sfd_pkg::PH_CHK_HI: begin
                push       = 1'b1;
                o_entry.op = sfd_pkg::OP_CHK_HI;
            end
            default: begin
                push = 1'b0;
            end
        endcase
        o_entry.data      = b;
        o_entry.hdr_class = n_class;
        o_entry.msg_id    = n_id;
        o_entry.length    = n_len;
    end

    assign o_push = acc && push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfd_pkg::PH_HUNT;
            r_max    <= sfd_pkg::MAX_LEN_RESET;
            r_class  <= 8'd0;
            r_id     <= 8'd0;
            r_len_lo <= 8'd0;
            r_len    <= 16'd0;
            r_cnt    <= 16'd0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.max_frame_len;
            end
            if (acc) begin
                r_phase  <= n_phase;
                r_class  <= n_class;
                r_id     <= n_id;
                r_len_lo <= n_len_lo;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
            end
        end
    end

endmodule

### rtl/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue
// Short FIFO of work entries between the parser and the back end.
// ----------------------------------------------------------------------------
module sfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfd_pkg::t_qentry  i_entry,
    input  logic              i_pop,
    output sfd_pkg::t_qstat   o_stat,
    output sfd_pkg::t_qentry  o_entry
);

    sfd_pkg::t_qentry r_slot [sfd_pkg::SFD_QDEPTH];
    logic [sfd_pkg::SFD_QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [sfd_pkg::SFD_QCNT_W-1:0] r_count;
    logic do_push, do_pop;

    function automatic logic [sfd_pkg::SFD_QPTR_W-1:0] ptr_next(
        input logic [sfd_pkg::SFD_QPTR_W-1:0] p
    );
        if (p == sfd_pkg::SFD_QPTR_W'(sfd_pkg::SFD_QDEPTH - 1)) begin
            return '0;
        end
        return p + sfd_pkg::SFD_QPTR_W'(1);
    endfunction

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == sfd_pkg::SFD_QCNT_W'(sfd_pkg::SFD_QDEPTH));
    assign o_entry      = r_slot[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + sfd_pkg::SFD_QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - sfd_pkg::SFD_QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Back end: runs the Fletcher sums, judges the check bytes and holds each
// result in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module sfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfd_pkg::t_qstat   i_qstat,
    input  sfd_pkg::t_qentry  i_entry,
    output logic              o_pop,
    sfd_out_if.source         o_res
);

    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_chk_lo, n_chk_lo;
    logic        r_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_class, r_id;
    logic [15:0] r_len, r_idx, n_idx;

    logic        emits;
    logic        out_free;
    logic [7:0]  sum_a_add;

    assign out_free  = !r_valid || o_res.ready;
    assign sum_a_add = r_sum_a + i_entry.data;

    always_comb begin
        emits    = 1'b0;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_chk_lo = r_chk_lo;
        n_kind   = sfd_pkg::KIND_PAYLOAD;
        n_data   = 8'd0;
        n_idx    = 16'd0;
        case (i_entry.op)
            sfd_pkg::OP_HEAD_FIRST: begin
                n_sum_a = i_entry.data;
                n_sum_b = i_entry.data;
            end
            sfd_pkg::OP_HEAD: begin
                n_sum_a = sum_a_add;
                n_sum_b = r_sum_b + sum_a_add;
            end
            sfd_pkg::OP_PAYLOAD: begin
                emits   = 1'b1;
                n_sum_a = sum_a_add;
                n_sum_b = r_sum_b + sum_a_add;
                n_data  = i_entry.data;
                n_idx   = i_entry.index;
            end
            sfd_pkg::OP_CHK_LO: begin
                n_chk_lo = i_entry.data;
            end
            sfd_pkg::OP_CHK_HI: begin
                emits  = 1'b1;
                n_kind = ((r_sum_a == r_chk_lo) && (r_sum_b == i_entry.data))
                       ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
            end
            sfd_pkg::OP_TOO_LONG: begin
                emits  = 1'b1;
                n_kind = sfd_pkg::KIND_TOO_LONG;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
    end

    // Stall only entries that need the output register
    assign o_pop = i_qstat.valid && (!emits || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_sum_a  <= 8'd0;
            r_sum_b  <= 8'd0;
            r_chk_lo <= 8'd0;
        end else begin
            if (o_pop) begin
                r_sum_a  <= n_sum_a;
                r_sum_b  <= n_sum_b;
                r_chk_lo <= n_chk_lo;
            end
            if (o_pop && emits) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emits) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_class <= i_entry.hdr_class;
            r_id    <= i_entry.msg_id;
            r_len   <= i_entry.length;
            r_idx   <= n_idx;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.kind          = r_kind;
    assign o_res.data_byte     = r_data;
    assign o_res.hdr_class     = r_class;
    assign o_res.msg_id        = r_id;
    assign o_res.hdr_length    = r_len;
    assign o_res.payload_index = r_idx;

endmodule
